>>> rtl/rhr_pkg.sv
// Shared types, sextant codes and a helper function for the hue rotation pipeline.
`timescale 1ns / 1ps

package rhr_pkg;

	// Sextant codes, named by channel order from largest to smallest.
	localparam logic [2:0] SX_RGB = 3'd0; // r >= g >= b, rising
	localparam logic [2:0] SX_GRB = 3'd1; // g >  r >= b, falling
	localparam logic [2:0] SX_GBR = 3'd2; // g >= b >  r, rising
	localparam logic [2:0] SX_BGR = 3'd3; // b >  g >  r, falling
	localparam logic [2:0] SX_BRG = 3'd4; // b >  r >= g, rising
	localparam logic [2:0] SX_RBG = 3'd5; // r >= b >  g, falling

	localparam logic [3:0] SX_COUNT = 4'd6;

	// Per-pixel context carried down the pipeline.
	typedef struct packed {
		logic       grey;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] delta;
		logic [2:0] sext;
	} rhr_ctx_t;

	// Partial state of the position divider.
	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] bits;
		logic [7:0] quo;
	} rhr_div_t;

	// floor(x / 255), exact while the quotient stays below 256.
	function automatic logic [7:0] div255(input logic [16:0] x);
		logic [16:0] t;
		begin
			t = x + {8'd0, x[16:8]} + 17'd1;
			return t[15:8];
		end
	endfunction

endpackage

>>> rtl/rhr_sort.sv
// First stage: sort the channels, pick the sextant, form the divider operands.
`timescale 1ns / 1ps

module rhr_sort (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output logic               out_valid,
	output rhr_pkg::rhr_ctx_t  ctx_s1,
	output rhr_pkg::rhr_div_t  div_s1
);

	logic [7:0]  hi, mid, lo, num;
	logic [2:0]  sext;
	logic [15:0] dividend;
	rhr_pkg::rhr_ctx_t ctx_d;

	always_comb begin
		if (red >= green) begin
			if (red >= blue) begin
				hi = red;
				if (green >= blue) begin
					mid = green; lo = blue; sext = rhr_pkg::SX_RGB;
				end else begin
					mid = blue; lo = green; sext = rhr_pkg::SX_RBG;
				end
			end else begin
				hi = blue; mid = red; lo = green; sext = rhr_pkg::SX_BRG;
			end
		end else begin
			if (green >= blue) begin
				hi = green;
				if (red >= blue) begin
					mid = red; lo = blue; sext = rhr_pkg::SX_GRB;
				end else begin
					mid = blue; lo = red; sext = rhr_pkg::SX_GBR;
				end
			end else begin
				hi = blue; mid = green; lo = red; sext = rhr_pkg::SX_BGR;
			end
		end

		// falling sextants measure from the top
		num      = sext[0] ? (hi - mid) : (mid - lo);
		dividend = {num, 8'd0} - {8'd0, num};

		ctx_d.grey  = (hi == lo);
		ctx_d.red   = red;
		ctx_d.green = green;
		ctx_d.blue  = blue;
		ctx_d.hi    = hi;
		ctx_d.lo    = lo;
		ctx_d.delta = hi - lo;
		ctx_d.sext  = sext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			ctx_s1       <= ctx_d;
			div_s1.rem   <= dividend[15:8];
			div_s1.bits  <= dividend[7:0];
			div_s1.quo   <= 8'd0;
		end
	end

endmodule

>>> rtl/rhr_div_stage.sv
// One divider stage: two restoring division steps toward the sextant position.
`timescale 1ns / 1ps

module rhr_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  rhr_pkg::rhr_ctx_t  ctx_in,
	input  rhr_pkg::rhr_div_t  div_in,
	output logic               out_valid,
	output rhr_pkg::rhr_ctx_t  ctx_q,
	output rhr_pkg::rhr_div_t  div_q
);

	rhr_pkg::rhr_div_t d;
	logic [8:0] t;

	always_comb begin
		d = div_in;
		for (int i = 0; i < 2; i++) begin
			t = {d.rem, d.bits[7]};
			if (t >= {1'b0, ctx_in.delta}) begin
				t     = t - {1'b0, ctx_in.delta};
				d.quo = {d.quo[6:0], 1'b1};
			end else begin
				d.quo = {d.quo[6:0], 1'b0};
			end
			// remainder stays below the divisor
			d.rem  = t[7:0];
			d.bits = {d.bits[6:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			ctx_q <= ctx_in;
			div_q <= d;
		end
	end

endmodule

>>> rtl/rhr_wrap.sv
// Add the hue shift to the position and wrap the sextant.
`timescale 1ns / 1ps

module rhr_wrap (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [10:0]        hue_shift,
	input  rhr_pkg::rhr_ctx_t  ctx_in,
	input  logic [7:0]         pos_in,
	output logic               out_valid,
	output rhr_pkg::rhr_ctx_t  ctx_s6,
	output logic [7:0]         pos_s6
);

	localparam logic [3:0] SX_COUNT_X2 = 4'(2 * rhr_pkg::SX_COUNT);

	logic [11:0] sum;
	logic [3:0]  t;
	logic [3:0]  wrapped;
	rhr_pkg::rhr_ctx_t ctx_d;

	always_comb begin
		sum = {4'd0, pos_in} + {1'b0, hue_shift};
		t   = {1'b0, ctx_in.sext} + sum[11:8];
		if (t >= {SX_COUNT_X2})
			wrapped = t - SX_COUNT_X2;
		else if (t >= rhr_pkg::SX_COUNT)
			wrapped = t - rhr_pkg::SX_COUNT;
		else
			wrapped = t;
		ctx_d      = ctx_in;
		ctx_d.sext = wrapped[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			ctx_s6 <= ctx_d;
			pos_s6 <= sum[7:0];
		end
	end

endmodule

>>> rtl/rhr_rebuild.sv
// Last two stages: scale the position by delta, then rebuild the channels.
`timescale 1ns / 1ps

module rhr_rebuild (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en_s7,
	input  logic               en_s8,
	input  logic               in_valid,
	input  rhr_pkg::rhr_ctx_t  ctx_in,
	input  logic [7:0]         pos_in,
	output logic               valid_s7,
	output logic               valid_s8,
	output logic [23:0]        pixel_s8
);

	rhr_pkg::rhr_ctx_t ctx_s7;
	logic [15:0] prod_s7;
	logic [7:0]  up, dn, inc, dec;
	logic [7:0]  ro, go, bo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (en_s7) begin
				valid_s7 <= in_valid;
			end
			if (en_s8) begin
				valid_s8 <= valid_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7 && in_valid) begin
			ctx_s7  <= ctx_in;
			prod_s7 <= {8'd0, ctx_in.delta} * {8'd0, pos_in};
		end
	end

	always_comb begin
		// floor and ceiling of delta*pos/255
		up  = rhr_pkg::div255({1'b0, prod_s7});
		dn  = rhr_pkg::div255({1'b0, prod_s7} + 17'd254);
		inc = ctx_s7.lo + up;
		dec = ctx_s7.hi - dn;
		unique case (ctx_s7.sext)
			rhr_pkg::SX_RGB: begin ro = ctx_s7.hi; go = inc;       bo = ctx_s7.lo; end
			rhr_pkg::SX_GRB: begin ro = dec;       go = ctx_s7.hi; bo = ctx_s7.lo; end
			rhr_pkg::SX_GBR: begin ro = ctx_s7.lo; go = ctx_s7.hi; bo = inc;       end
			rhr_pkg::SX_BGR: begin ro = ctx_s7.lo; go = dec;       bo = ctx_s7.hi; end
			rhr_pkg::SX_BRG: begin ro = inc;       go = ctx_s7.lo; bo = ctx_s7.hi; end
			default:         begin ro = ctx_s7.hi; go = ctx_s7.lo; bo = dec;       end
		endcase
		if (ctx_s7.grey) begin
			ro = ctx_s7.red;
			go = ctx_s7.green;
			bo = ctx_s7.blue;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8 && valid_s7) begin
			pixel_s8 <= {bo, go, ro};
		end
	end

endmodule

>>> rtl/rgb_hue_rotate_top.sv
// Top level of the RGB hue rotation pipeline.
`timescale 1ns / 1ps

// Channel      Direction  Transaction
// s_*          in         one RGB pixel: tdata = red, green, blue (low to high)
// m_*          out        one rotated pixel, same packing as the input
// hue_shift_*  in         write of the hue shift register, no handshake
//
// Every pixel passes through the pipeline stages: sort, four divider stages of two
// quotient bits each, shift and wrap, the delta*position multiply, then the rebuild
// that lands in the output register. One pixel enters per clock while s_tready is high.
// Reset clears all valid bits and sets the hue shift to zero.
// A stage advances whenever it is empty or the stage after it advances, so bubbles
// collapse and a stalled output holds its pixel while upstream keeps filling.

module rgb_hue_rotate_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,          // red_in, green_in, blue_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,          // red_out, green_out, blue_out
	input  logic        hue_shift_wr_en,
	input  logic [10:0] hue_shift_wr_data
);

	localparam int DIV_STAGES = 4;

	logic [10:0] hue_shift_q;

	// stage valids and enables; index 0 is the sort stage
	logic [DIV_STAGES:0]      dv;
	logic [DIV_STAGES:0]      den;
	rhr_pkg::rhr_ctx_t        dctx [DIV_STAGES+1];
	rhr_pkg::rhr_div_t        ddiv [DIV_STAGES+1];

	logic                     v6, en6;
	logic                     v7, en7, en8;
	rhr_pkg::rhr_ctx_t        ctx6;
	logic [7:0]               pos6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_shift_q <= 11'd0;
		end else if (hue_shift_wr_en) begin
			hue_shift_q <= hue_shift_wr_data;
		end
	end

	// Advance chain: output register first, then back toward the input.
	assign en8 = !m_tvalid || m_tready;
	assign en7 = !v7 || en8;
	assign en6 = !v6 || en7;

	always_comb begin
		den[DIV_STAGES] = !dv[DIV_STAGES] || en6;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			den[k] = !dv[k] || den[k+1];
		end
	end

	assign s_tready = den[0];

	rhr_sort u_sort (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (den[0]),
		.in_valid  (s_tvalid),
		.red       (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.blue      (s_tdata[23:16]),
		.out_valid (dv[0]),
		.ctx_s1    (dctx[0]),
		.div_s1    (ddiv[0])
	);

	// Position = 255*num/delta, two quotient bits per stage.
	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		rhr_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (den[k]),
			.in_valid  (dv[k-1]),
			.ctx_in    (dctx[k-1]),
			.div_in    (ddiv[k-1]),
			.out_valid (dv[k]),
			.ctx_q     (dctx[k]),
			.div_q     (ddiv[k])
		);
	end

	rhr_wrap u_wrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en6),
		.in_valid  (dv[DIV_STAGES]),
		.hue_shift (hue_shift_q),
		.ctx_in    (dctx[DIV_STAGES]),
		.pos_in    (ddiv[DIV_STAGES].quo),
		.out_valid (v6),
		.ctx_s6    (ctx6),
		.pos_s6    (pos6)
	);

	rhr_rebuild u_rebuild (
		.clk      (clk),
		.arst_n   (arst_n),
		.en_s7    (en7),
		.en_s8    (en8),
		.in_valid (v6),
		.ctx_in   (ctx6),
		.pos_in   (pos6),
		.valid_s7 (v7),
		.valid_s8 (m_tvalid),
		.pixel_s8 (m_tdata)
	);

endmodule
